// ----- rtl/ose_pkg.sv -----
`default_nettype none

package ose_pkg;

    localparam int WORD_W       = 64;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int DEPTH_W      = 8;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_DUP   = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;

    localparam logic [1:0] SEL_FREE   = 2'd0;
    localparam logic [1:0] SEL_TOP    = 2'd1;
    localparam logic [1:0] SEL_SECOND = 2'd2;

    localparam logic [1:0] WD_PUSH  = 2'd0;
    localparam logic [1:0] WD_RDATA = 2'd1;
    localparam logic [1:0] WD_TMP   = 2'd2;

    localparam logic [1:0] CNT_HOLD = 2'd0;
    localparam logic [1:0] CNT_INC  = 2'd1;
    localparam logic [1:0] CNT_DEC  = 2'd2;
    localparam logic [1:0] CNT_CLR  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   req_type;
        logic [WORD_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]   read_word;
        logic [STATUS_W-1:0] status;
        logic [DEPTH_W-1:0]  depth_now;
    } rsp_t;

    typedef struct packed {
        logic                req_load;
        logic                rd_en;
        logic [1:0]          rd_sel;
        logic                wr_en;
        logic [1:0]          wr_sel;
        logic [1:0]          wd_sel;
        logic                tmp_load;
        logic [1:0]          cnt_op;
        logic                res_set;
        logic [STATUS_W-1:0] res_status;
        logic                res_word;
        logic                out_load;
    } ose_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            empty;
        logic            full;
        logic            lt2;
        logic            out_free;
    } ose_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ose_ctrl.sv -----
`default_nettype none

module ose_ctrl
    import ose_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ose_stat_t stat,
    output ose_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_DUPW   = 3'd2;
    localparam logic [2:0] S_SWPA   = 3'd3;
    localparam logic [2:0] S_SWPB   = 3'd4;
    localparam logic [2:0] S_SWPC   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.req_load = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_FINISH;
                unique case (stat.op)
                    OP_PUSH: begin
                        if (stat.full) begin
                            cmd.res_status = ST_OVER;
                        end else begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = SEL_FREE;
                            cmd.wd_sel = WD_PUSH;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    OP_POP: begin
                        if (stat.empty) begin
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = SEL_TOP;
                            cmd.cnt_op   = CNT_DEC;
                            cmd.res_word = 1'b1;
                        end
                    end
                    OP_PEEK: begin
                        if (stat.empty) begin
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = SEL_TOP;
                            cmd.res_word = 1'b1;
                        end
                    end
                    OP_DUP: begin
                        if (stat.empty) begin
                            cmd.res_status = ST_UNDER;
                        end else if (stat.full) begin
                            cmd.res_status = ST_OVER;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = SEL_TOP;
                            state_next = S_DUPW;
                        end
                    end
                    OP_SWAP: begin
                        if (stat.lt2) begin
                            cmd.res_status = ST_UNDER;
                        end else begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = SEL_TOP;
                            state_next = S_SWPA;
                        end
                    end
                    OP_CLEAR: begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    default: begin
                    end
                endcase
            end
            S_DUPW: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_FREE;
                cmd.wd_sel = WD_RDATA;
                cmd.cnt_op = CNT_INC;
                state_next = S_FINISH;
            end
            S_SWPA: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = SEL_SECOND;
                cmd.tmp_load = 1'b1;
                state_next   = S_SWPB;
            end
            S_SWPB: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_SECOND;
                cmd.wd_sel = WD_TMP;
                state_next = S_SWPC;
            end
            S_SWPC: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = SEL_TOP;
                cmd.wd_sel = WD_RDATA;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/ose_dpath.sv -----
`default_nettype none

module ose_dpath
    import ose_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire req_t     s_data,
    input  wire ose_cmd_t cmd,
    output ose_stat_t     stat,
    output logic          m_valid,
    input  wire logic     m_ready,
    output rsp_t          m_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [WORD_W-1:0]   mem [STACK_DEPTH];

    logic [OP_W-1:0]     op_reg;
    logic [WORD_W-1:0]   word_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic [WORD_W-1:0]   rdata_reg;
    logic [WORD_W-1:0]   tmp_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                res_word_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    rsp_t                rsp_reg;

    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       cnt_m2;
    logic [AW-1:0]       addr_free;
    logic [AW-1:0]       addr_top;
    logic [AW-1:0]       addr_second;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic [WORD_W-1:0]   wr_data;

    assign cnt_m1      = count_reg - CW'(1);
    assign cnt_m2      = count_reg - CW'(2);
    assign addr_free   = count_reg[AW-1:0];
    assign addr_top    = cnt_m1[AW-1:0];
    assign addr_second = cnt_m2[AW-1:0];

    assign rd_addr = (cmd.rd_sel == SEL_SECOND) ? addr_second : addr_top;

    always_comb begin
        unique case (cmd.wr_sel)
            SEL_TOP:    wr_addr = addr_top;
            SEL_SECOND: wr_addr = addr_second;
            default:    wr_addr = addr_free;
        endcase
    end

    always_comb begin
        unique case (cmd.wd_sel)
            WD_RDATA: wr_data = rdata_reg;
            WD_TMP:   wr_data = tmp_reg;
            default:  wr_data = word_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.req_load) begin
            op_reg   <= s_data.req_type;
            word_reg <= s_data.push_value;
        end
        if (cmd.tmp_load) begin
            tmp_reg <= rdata_reg;
        end
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            res_word_reg   <= cmd.res_word;
        end
        if (cmd.out_load) begin
            rsp_reg.read_word <= res_word_reg ? rdata_reg : '0;
            rsp_reg.status    <= res_status_reg;
            rsp_reg.depth_now <= DEPTH_W'(count_reg);
        end
    end

    always_comb begin
        unique case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = cnt_m1;
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign stat.op       = op_reg;
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CW'(STACK_DEPTH));
    assign stat.lt2      = (count_reg < CW'(2));
    assign stat.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en && cmd.wr_sel == SEL_FREE) |-> !stat.full)
        else $error("write above top of full stack");

    a_second_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.rd_sel == SEL_SECOND) |-> !stat.lt2)
        else $error("second entry read with fewer than two entries");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    a_count_moves_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.cnt_op == CNT_INC) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("count increment lost");
`endif

endmodule

`default_nettype wire

// ----- rtl/operand_stack_engine_unit.sv -----
// Channel  Ports                       Payload  Transaction
// input    s_valid, s_ready, s_data    req_t    one stack request
// result   m_valid, m_ready, m_data    rsp_t    one result per request
//
// One request at a time. Push, pop, peek, clear and unused codes run an execute
// and a finish state; duplicate adds a write state and swap adds read, write and
// write states, as the controller makes at most one stack memory access per state
// (registered read). The result is loaded into the output register once it is free.
// A new request is taken once the previous result sits in the output register;
// it holds in its finish state while that result is stalled by m_ready.
// Synchronous active-low reset empties the stack; stored words stay undefined.
`default_nettype none

module operand_stack_engine_unit
    import ose_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_data
);

    ose_cmd_t  cmd;
    ose_stat_t stat;

    ose_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ose_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- sim/operand_stack_engine_unit_test.sv -----
`default_nettype none

module operand_stack_engine_unit_test;
    import ose_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int CALM_ITEMS    = 200;
    localparam int SEGMENT_ITEMS = 250;
    localparam int PAUSE_EVERY   = 650;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 12;

    typedef enum logic [1:0] {BIAS_FILL, BIAS_MIX, BIAS_DRAIN} bias_t;

    class stack_scoreboard;
        logic [WORD_W-1:0] words [STACK_DEPTH_DEF];
        int unsigned held;
        rsp_t expected_q[$];
        int errors;
        int matched;
        int overflows;
        int underflows;
        int unsigned peak;

        function void note_request(req_t r);
            rsp_t e;
            logic [WORD_W-1:0] t;
            e.read_word = '0;
            e.status = ST_OK;
            unique case (r.req_type)
                OP_PUSH: begin
                    if (held >= STACK_DEPTH_DEF) begin
                        e.status = ST_OVER;
                    end else begin
                        words[held] = r.push_value;
                        held++;
                    end
                end
                OP_POP: begin
                    if (held == 0) begin
                        e.status = ST_UNDER;
                    end else begin
                        held--;
                        e.read_word = words[held];
                    end
                end
                OP_PEEK: begin
                    if (held == 0) e.status = ST_UNDER;
                    else e.read_word = words[held-1];
                end
                OP_DUP: begin
                    if (held == 0) begin
                        e.status = ST_UNDER;
                    end else if (held >= STACK_DEPTH_DEF) begin
                        e.status = ST_OVER;
                    end else begin
                        words[held] = words[held-1];
                        held++;
                    end
                end
                OP_SWAP: begin
                    if (held < 2) begin
                        e.status = ST_UNDER;
                    end else begin
                        t = words[held-1];
                        words[held-1] = words[held-2];
                        words[held-2] = t;
                    end
                end
                OP_CLEAR: held = 0;
                default: ;
            endcase
            if (e.status == ST_OVER) overflows++;
            if (e.status == ST_UNDER) underflows++;
            if (held > peak) peak = held;
            e.depth_now = DEPTH_W'(held);
            expected_q.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result %h", $time, got);
                return;
            end
            e = expected_q.pop_front();
            if (got.read_word !== e.read_word) begin
                errors++;
                $display("%0t read_word expected %h got %h", $time, e.read_word, got.read_word);
            end
            if (got.status !== e.status) begin
                errors++;
                $display("%0t status expected %0d got %0d", $time, e.status, got.status);
            end
            if (got.depth_now !== e.depth_now) begin
                errors++;
                $display("%0t depth_now expected %0d got %0d", $time, e.depth_now,
                         got.depth_now);
            end
            matched++;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    stack_scoreboard sb = new;
    bit calm = 1'b0;
    int unsigned op_tally [8];
    int idle_cycles = 0;

    operand_stack_engine_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("operand_stack_engine_unit_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // hold off the result channel in random bursts
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_request(input req_t r);
        if (!calm && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
        op_tally[r.req_type]++;
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] value);
        req_t r;
        r.req_type = op;
        r.push_value = value;
        send_request(r);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    function automatic req_t pick_request(bias_t bias);
        req_t r;
        int roll;
        int cut [6];
        roll = $urandom_range(0, 99);
        r.push_value = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) r.push_value = '0;
        else if ($urandom_range(0, 15) == 0) r.push_value = '1;
        unique case (bias)
            BIAS_FILL:  cut = '{55, 62, 69, 89, 97, 98};
            BIAS_DRAIN: cut = '{10, 70, 80, 85, 95, 98};
            default:    cut = '{30, 58, 68, 78, 90, 94};
        endcase
        if (roll < cut[0]) r.req_type = OP_PUSH;
        else if (roll < cut[1]) r.req_type = OP_POP;
        else if (roll < cut[2]) r.req_type = OP_PEEK;
        else if (roll < cut[3]) r.req_type = OP_DUP;
        else if (roll < cut[4]) r.req_type = OP_SWAP;
        else if (roll < cut[5]) r.req_type = OP_CLEAR;
        else r.req_type = $urandom_range(0, 1) ? OP_RSVD_HI : OP_RSVD_LO;
        return r;
    endfunction

    initial begin
        req_t r;
        bias_t bias;
        int counted;
        int next_pause;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        send_op(OP_POP, '1);
        send_op(OP_PEEK, '0);
        send_op(OP_DUP, '1);
        send_op(OP_SWAP, '0);
        send_op(OP_PUSH, '0);
        send_op(OP_SWAP, '1);
        send_op(OP_PUSH, '1);
        send_op(OP_PEEK, '0);
        send_op(OP_SWAP, '0);
        send_op(OP_PEEK, '1);
        send_op(OP_DUP, '0);
        send_op(OP_POP, '0);
        send_op(OP_POP, '1);
        send_op(OP_POP, '0);
        send_op(OP_POP, '0);
        send_op(OP_PUSH, 64'h8000_0000_0000_0001);
        send_op(OP_RSVD_LO, '1);
        send_op(OP_RSVD_HI, '0);
        send_op(OP_CLEAR, '1);
        send_op(OP_POP, '0);
        send_op(OP_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
        send_op(OP_PUSH, 64'h5555_5555_5555_5555);
        send_op(OP_SWAP, '0);
        send_op(OP_POP, '0);
        send_op(OP_CLEAR, '0);

        // fill to the top, then hit push and duplicate on a full stack
        repeat (STACK_DEPTH_DEF) send_op(OP_PUSH, {$urandom, $urandom});
        send_op(OP_PUSH, '1);
        send_op(OP_DUP, '0);
        send_op(OP_SWAP, '0);
        send_op(OP_PEEK, '0);
        send_op(OP_POP, '0);
        send_op(OP_DUP, '0);
        send_op(OP_DUP, '0);
        send_op(OP_CLEAR, '0);

        counted = 0;
        next_pause = PAUSE_EVERY;
        while (counted < RANDOM_ITEMS) begin
            if (counted == next_pause) begin
                wait_drained();
                next_pause += PAUSE_EVERY;
            end
            calm = (counted >= RANDOM_ITEMS - CALM_ITEMS);
            unique case ((counted / SEGMENT_ITEMS) % 4)
                0, 2:    bias = BIAS_FILL;
                1:       bias = BIAS_MIX;
                default: bias = BIAS_DRAIN;
            endcase
            r = pick_request(bias);
            send_request(r);
            if (r.req_type <= OP_CLEAR) counted++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d results; requests by code 0-7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.matched, op_tally[0], op_tally[1], op_tally[2], op_tally[3],
                 op_tally[4], op_tally[5], op_tally[6], op_tally[7]);
        $display("peak depth %0d, %0d overflow and %0d underflow results",
                 sb.peak, sb.overflows, sb.underflows);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("operand_stack_engine_unit_test: PASS");
        end else begin
            $display("operand_stack_engine_unit_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
